/* rtl/simpson_integrator_square_macros.svh */
// Assertion macros shared by the Simpson integrator RTL.
// Assumes a clock i_clk and an active-low synchronous reset i_rst_n in scope.
`ifndef SIMPSON_INTEGRATOR_SQUARE_MACROS_SVH
`define SIMPSON_INTEGRATOR_SQUARE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sis_pkg.sv */
// Package for the Simpson integrator: fixed-point formats, widths,
// controller states and the controller/datapath command and status structs.
package sis_pkg;

    localparam int IN_W              = 24;
    localparam int COUNT_W           = 21;
    localparam int OUT_W             = 48;
    localparam int DEF_MAX_INTERVALS = 1048576;
    localparam int FRACTION_BITS     = 16;

    localparam int X_FRAC    = FRACTION_BITS + 8;
    localparam int H_FRAC    = FRACTION_BITS + 24;
    localparam int H_EXTRA   = H_FRAC - FRACTION_BITS;
    localparam int X_DROP    = H_FRAC - X_FRAC;
    localparam int OUT_SHIFT = X_FRAC + H_FRAC - FRACTION_BITS;

    // step magnitude, sample point, truncated magnitude, truncated square
    localparam int H_W  = IN_W + H_EXTRA;
    localparam int X_W  = H_W + 1;
    localparam int M_W  = X_W - 1 - X_DROP;
    localparam int SQ_W = 2 * M_W - X_FRAC;

    // final scaling multiply: step magnitude consumed in digits
    localparam int DIG_W  = 16;
    localparam int DIGITS = H_W / DIG_W;
    localparam int DIV3   = 3;
    // final divide by three: quotient bits resolved per cycle
    localparam int DIV3_BITS = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_HDIV,
        ST_HWAIT,
        ST_PT_A,
        ST_PT_INNER,
        ST_PT_B,
        ST_DRAIN,
        ST_MUL,
        ST_MWAIT,
        ST_DIV3,
        ST_DWAIT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PT_NONE,
        PT_A,
        PT_STEP,
        PT_B
    } t_pt_kind;

    typedef enum logic [1:0] {
        W_ONE,
        W_TWO,
        W_FOUR
    } t_weight;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     d3_start;
        logic     cap_h;
        t_pt_kind pt;
        logic     mul_start;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic zero_count;
        logic div_busy;
        logic last_inner;
        logic pipe_busy;
        logic mul_busy;
        logic d3_busy;
    } t_dp_sts;

endpackage

/* rtl/sis_if.sv */
// Handshake interfaces for the Simpson integrator input and result channels.
// Depends on sis_pkg for the field widths.
interface sis_in_if import sis_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [IN_W-1:0]    lower_bound;
    logic signed [IN_W-1:0]    upper_bound;
    logic        [COUNT_W-1:0] interval_count;

    modport source (output valid, lower_bound, upper_bound, interval_count, input ready);
    modport sink   (input valid, lower_bound, upper_bound, interval_count, output ready);
endinterface

interface sis_out_if import sis_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] integral;
    logic                    status;

    modport source (output valid, integral, status, input ready);
    modport sink   (input valid, integral, status, output ready);
endinterface

/* rtl/simpson_integrator_square.sv */
// Simpson integrator for x squared. One transaction carries a lower bound, an upper bound
// (signed Q8.16) and an interval count; one result transaction returns the integral in
// signed Q32.16 and a status bit (1 when the count is zero, integral then 0). Odd counts are
// raised by one and counts above MAX_INTERVALS are clamped to its even floor. The block
// works on one transaction at a time: a zero count goes from the count check straight to the
// result load; otherwise, with n the adjusted count, the steps are setup with the bit-serial
// step division (48 quotient bits, one per cycle), the sweep of the n + 1 sample points, one
// per cycle, through the squaring multiplier, the drain of the squaring pipeline, the scaling
// multiply (three 16-bit digits of the step), the divide by three (16 quotient bits per cycle)
// and the result load. A new transaction is accepted the cycle after the previous result is
// loaded, even while the consumer has not taken it yet; a result still waiting when the next
// one is done stalls the block.
module simpson_integrator_square import sis_pkg::*; #(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS
) (
    input logic      i_clk,
    input logic      i_rst_n,
    sis_in_if.sink   i_in,
    sis_out_if.source o_out
);
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;
    logic    w_out_valid;

    // sequencer: handshakes and stepping of the datapath
    sis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // arithmetic: step, sample squares, weighted sum, scaling, result register
    sis_dp #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_lower_bound    (i_in.lower_bound),
        .i_upper_bound    (i_in.upper_bound),
        .i_interval_count (i_in.interval_count),
        .o_integral       (o_out.integral),
        .o_status         (o_out.status)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
endmodule

/* rtl/sis_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module sis_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_trial;
    logic             w_fits;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            // shift in the next dividend bit, subtract when it fits
            r_quo <= {r_quo[DVD_W-2:0], w_fits};
            r_rem <= w_fits ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;
endmodule

/* rtl/sis_dp.sv */
// Datapath of the Simpson integrator: operand capture, step division,
// sample-point squaring pipeline, weighted sum, final scaling and result.
// Depends on sis_pkg and sis_div.
module sis_dp import sis_pkg::*; #(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic signed [IN_W-1:0]    i_lower_bound,
    input  logic signed [IN_W-1:0]    i_upper_bound,
    input  logic        [COUNT_W-1:0] i_interval_count,
    output logic signed [OUT_W-1:0]   o_integral,
    output logic                      o_status
);
    localparam int CNT_W   = $clog2(MAX_INTERVALS + 1);
    localparam int CMP_W   = (CNT_W > COUNT_W + 1) ? CNT_W : COUNT_W + 1;
    localparam int SUM_W   = SQ_W + $clog2(3 * MAX_INTERVALS);
    localparam int PROD_W  = SUM_W + H_W;
    localparam int DIGC_W  = $clog2(DIGITS + 1);
    localparam int Q_W     = PROD_W - OUT_SHIFT;
    localparam int D3_W    = ((Q_W + DIV3_BITS - 1) / DIV3_BITS) * DIV3_BITS;
    localparam int D3C_W   = $clog2(D3_W / DIV3_BITS + 1);
    localparam logic [CMP_W-1:0] MAX_EVEN = CMP_W'(MAX_INTERVALS) & ~CMP_W'(1);

    // captured operands
    logic signed [IN_W-1:0] r_a;
    logic signed [IN_W-1:0] r_b;
    logic [CNT_W-1:0]       r_n;
    logic [CMP_W-1:0]       w_n_even;

    assign w_n_even = CMP_W'(i_interval_count) + CMP_W'(i_interval_count[0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_lower_bound;
            r_b <= i_upper_bound;
            r_n <= (w_n_even > MAX_EVEN) ? CNT_W'(MAX_EVEN) : CNT_W'(w_n_even);
        end
    end

    // bound difference and its magnitude
    logic signed [IN_W:0] w_diff;
    logic [IN_W:0]        w_diff_mag;

    assign w_diff     = (IN_W + 1)'(r_b) - (IN_W + 1)'(r_a);
    assign w_diff_mag = w_diff[IN_W] ? $unsigned(-w_diff) : $unsigned(w_diff);

    // step size divider
    logic               w_div_busy;
    logic [H_W-1:0]     w_quo;
    logic [PROD_W-1:0]  r_acc;

    sis_div #(
        .DVD_W (H_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({w_diff_mag[IN_W-1:0], {H_EXTRA{1'b0}}}),
        .i_divisor  (r_n),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // signed step, kept both as magnitude and as an addend
    logic [H_W-1:0]        r_hmag;
    logic signed [X_W-1:0] r_hstep;
    logic                  r_neg;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_h) begin
            r_hmag  <= w_quo;
            r_neg   <= w_diff[IN_W];
            r_hstep <= w_diff[IN_W] ? -$signed({1'b0, w_quo})
                                    : $signed({1'b0, w_quo});
        end
    end

    // sample point generator
    logic signed [X_W-1:0] r_x;
    logic [CNT_W-1:0]      r_i;
    t_weight               r_w0, r_w1, r_w2;
    logic                  r_v0, r_v1, r_v2;

    always_ff @(posedge i_clk) begin
        case (i_cmd.pt)
            PT_A: begin
                r_x  <= X_W'($signed({r_a, {H_EXTRA{1'b0}}}));
                r_w0 <= W_ONE;
                r_i  <= '0;
            end
            PT_STEP: begin
                r_x  <= r_x + r_hstep;
                r_w0 <= r_i[0] ? W_TWO : W_FOUR;
                r_i  <= r_i + 1'b1;
            end
            PT_B: begin
                r_x  <= X_W'($signed({r_b, {H_EXTRA{1'b0}}}));
                r_w0 <= W_ONE;
            end
            default: begin
            end
        endcase
    end

    // squaring pipeline: magnitude, square, weighted accumulate
    logic [X_W-1:0]   w_xmag;
    logic [M_W-1:0]   r_m;
    logic [2*M_W-1:0] w_sq;
    logic [SQ_W-1:0]  r_f;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] w_add;

    assign w_xmag = r_x[X_W-1] ? $unsigned(-r_x) : $unsigned(r_x);
    assign w_sq   = r_m * r_m;

    always_comb begin
        case (r_w2)
            W_ONE:   w_add = SUM_W'(r_f);
            W_TWO:   w_add = SUM_W'({r_f, 1'b0});
            W_FOUR:  w_add = SUM_W'({r_f, 2'b00});
            default: w_add = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.pt != PT_NONE;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m  <= w_xmag[X_W-2:X_DROP];
        r_w1 <= r_w0;
        r_f  <= w_sq[2*M_W-1:X_FRAC];
        r_w2 <= r_w1;
        if (i_cmd.pt == PT_A) begin
            r_sum <= '0;
        end else if (r_v2) begin
            r_sum <= r_sum + w_add;
        end
    end

    // sum times step magnitude, one digit of the step per cycle
    logic [DIGC_W-1:0]      r_dig;
    logic [H_W-1:0]         r_hsh;
    logic [SUM_W+DIG_W-1:0] w_pp;

    assign w_pp = r_sum * r_hsh[H_W-1 -: DIG_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dig <= '0;
        end else if (i_cmd.mul_start) begin
            r_dig <= DIGC_W'(DIGITS);
        end else if (r_dig != '0) begin
            r_dig <= r_dig - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_acc <= '0;
            r_hsh <= r_hmag;
        end else if (r_dig != '0) begin
            r_acc <= (r_acc << DIG_W) + PROD_W'(w_pp);
            r_hsh <= r_hsh << DIG_W;
        end
    end

    // divide the scaled sum by three, compare and subtract, MSB first
    logic [D3_W-1:0]      r_d3x;
    logic [D3_W-1:0]      r_d3q;
    logic [1:0]           r_d3r;
    logic [D3C_W-1:0]     r_d3c;
    logic [DIV3_BITS-1:0] w_d3q;
    logic [1:0]           w_d3r;

    always_comb begin
        logic [2:0] v;
        w_d3r = r_d3r;
        for (int j = 0; j < DIV3_BITS; j++) begin
            v                    = {w_d3r, r_d3x[D3_W-1-j]};
            w_d3q[DIV3_BITS-1-j] = v >= 3'(DIV3);
            w_d3r                = (v >= 3'(DIV3)) ? 2'(v - 3'(DIV3)) : v[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d3c <= '0;
        end else if (i_cmd.d3_start) begin
            r_d3c <= D3C_W'(D3_W / DIV3_BITS);
        end else if (r_d3c != '0) begin
            r_d3c <= r_d3c - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.d3_start) begin
            r_d3x <= D3_W'(r_acc[PROD_W-1:OUT_SHIFT]);
            r_d3q <= '0;
            r_d3r <= '0;
        end else if (r_d3c != '0) begin
            r_d3x <= r_d3x << DIV3_BITS;
            r_d3q <= (r_d3q << DIV3_BITS) | D3_W'(w_d3q);
            r_d3r <= w_d3r;
        end
    end

    // result register
    logic [OUT_W-1:0] w_qres;

    assign w_qres = r_d3q[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status <= r_n == '0;
            if (r_n == '0) begin
                o_integral <= '0;
            end else begin
                o_integral <= r_neg ? -$signed(w_qres) : $signed(w_qres);
            end
        end
    end

    assign o_sts.zero_count = r_n == '0;
    assign o_sts.div_busy   = w_div_busy;
    assign o_sts.last_inner = ((CNT_W + 1)'(r_i) + (CNT_W + 1)'(2)) == (CNT_W + 1)'(r_n);
    assign o_sts.pipe_busy  = r_v0 | r_v1 | r_v2;
    assign o_sts.mul_busy   = r_dig != '0;
    assign o_sts.d3_busy    = r_d3c != '0;
endmodule

/* rtl/sis_ctrl.sv */
// Sequencer of the Simpson integrator: drives the datapath through capture,
// step division, sample sweep, scaling and result hand-off.
// Depends on sis_pkg and the assertion macro header.
`include "simpson_integrator_square_macros.svh"

module sis_ctrl import sis_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);
    t_state r_state, n_state;
    logic   r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.d3_start  = 1'b0;
        o_cmd.cap_h     = 1'b0;
        o_cmd.pt        = PT_NONE;
        o_cmd.mul_start = 1'b0;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: n_state = i_sts.zero_count ? ST_DONE : ST_HDIV;
            ST_HDIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_HWAIT;
            end
            ST_HWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.cap_h = 1'b1;
                    n_state     = ST_PT_A;
                end
            end
            ST_PT_A: begin
                o_cmd.pt = PT_A;
                n_state  = ST_PT_INNER;
            end
            ST_PT_INNER: begin
                o_cmd.pt = PT_STEP;
                if (i_sts.last_inner) begin
                    n_state = ST_PT_B;
                end
            end
            ST_PT_B: begin
                o_cmd.pt = PT_B;
                n_state  = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state         = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (!i_sts.mul_busy) begin
                    n_state = ST_DIV3;
                end
            end
            ST_DIV3: begin
                o_cmd.d3_start = 1'b1;
                n_state        = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (!i_sts.d3_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free or being drained
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_vld;

    `SIS_ASSERT_NXT(a_accept_to_check, i_in_valid && o_in_ready, r_state == ST_CHECK, "no check")
    `SIS_ASSERT_NXT(a_load_sets_valid, o_cmd.out_load, r_out_vld, "load lost output valid")
    `SIS_ASSERT_NOW(a_div_start_idle, o_cmd.div_start, !i_sts.div_busy, "divider restarted")
    `SIS_ASSERT_NOW(a_mul_after_drain, o_cmd.mul_start, !i_sts.pipe_busy, "scaling too early")
    `SIS_ASSERT_NOW(a_d3_after_mul, o_cmd.d3_start, !i_sts.mul_busy, "divide by three too early")
endmodule

/* sim/simpson_integrator_square_checker.sv */
`timescale 1ns / 100ps
// Checker for the Simpson integrator: watches both channels, predicts each result
// from the accepted request and compares it. Depends on sis_pkg and sis_if.sv.
module simpson_integrator_square_checker import sis_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sis_in_if    i_in,
    sis_out_if   i_out,
    output int   o_pending,
    output int   o_error_count
);

    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_ZERO_COUNT = 1'b1;
    localparam longint unsigned COUNT_LIMIT = longint'(DEF_MAX_INTERVALS) & ~64'd1;

    typedef struct {
        logic signed [OUT_W-1:0] integral;
        logic                    status;
    } t_integral_result;

    t_integral_result integral_queue[$];
    int               errors = 0;

    // Square a Q.40 point: truncate the magnitude to Q.24, square, drop back to Q.24.
    function automatic longint unsigned point_square(input longint x);
        longint unsigned m;
        m = (x < 0) ? longint'(-x) : longint'(x);
        m = m >> X_DROP;
        return (m * m) >> X_FRAC;
    endfunction

    function automatic t_integral_result integrate_x_squared(
        input logic signed [IN_W-1:0]  lo,
        input logic signed [IN_W-1:0]  hi,
        input logic [COUNT_W-1:0]      cnt
    );
        t_integral_result r;
        longint unsigned  steps, diff_mag, step_mag, weighted_sum, fx, i;
        longint           diff, step, lo_fixed, hi_fixed;
        logic [127:0]     product;
        logic [63:0]      scaled;
        logic             neg;
        r.integral = '0;
        r.status   = STATUS_OK;
        if (cnt == 0) begin
            r.status = STATUS_ZERO_COUNT;
            return r;
        end
        steps = longint'(cnt) + longint'(cnt[0]);
        if (steps > COUNT_LIMIT)
            steps = COUNT_LIMIT;

        diff     = longint'(hi) - longint'(lo);
        neg      = diff < 0;
        diff_mag = neg ? longint'(-diff) : longint'(diff);
        step_mag = (diff_mag << H_EXTRA) / steps;
        step     = neg ? -longint'(step_mag) : longint'(step_mag);

        lo_fixed = longint'(lo) * (longint'(1) << H_EXTRA);
        hi_fixed = longint'(hi) * (longint'(1) << H_EXTRA);

        // end points weigh 1, odd inner points 4, even inner points 2
        weighted_sum = point_square(lo_fixed) + point_square(hi_fixed);
        for (i = 1; i < steps; i++) begin
            fx = point_square(lo_fixed + longint'(i) * step);
            weighted_sum += i[0] ? 64'd4 * fx : 64'd2 * fx;
        end

        product = {64'd0, weighted_sum} * {64'd0, step_mag};
        scaled  = product[OUT_SHIFT +: 64];
        scaled  = scaled / 64'd3;
        if (neg)
            scaled = -scaled;
        r.integral = scaled[OUT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_integral_result want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready)
                integral_queue.push_back(integrate_x_squared(i_in.lower_bound,
                    i_in.upper_bound, i_in.interval_count));
            if (i_out.valid && i_out.ready) begin
                if (integral_queue.size() == 0) begin
                    $display("%0t: result with nothing expected: integral %0d status %0d",
                        $time, i_out.integral, i_out.status);
                    errors++;
                end else begin
                    want = integral_queue.pop_front();
                    if (i_out.integral !== want.integral) begin
                        $display("%0t: integral mismatch: expected %0d, actual %0d",
                            $time, want.integral, i_out.integral);
                        errors++;
                    end
                    if (i_out.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                            $time, want.status, i_out.status);
                        errors++;
                    end
                end
            end
        end
        o_pending     <= integral_queue.size();
        o_error_count <= errors;
    end

endmodule

/* sim/simpson_integrator_square_tb.sv */
`timescale 1ns / 100ps
// Top of the Simpson integrator testbench: clock, reset, request stimulus and the
// result-side stall pattern. Depends on sis_pkg, sis_if.sv and the checker module.
module simpson_integrator_square_tb;
    import sis_pkg::*;

    localparam int     CLK_HALF     = 6;
    localparam int     RANDOM_ITEMS = 100;
    localparam int     DRAIN_CYCLES = 400;
    // hard-stop time, several times the slowest legal run
    localparam longint LIMIT_NS     = 64'd8_000_000 * 2 * CLK_HALF;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   idle_pct = 8;
    int   pending;
    int   error_count;

    sis_in_if  req_ch();
    sis_out_if res_ch();

    simpson_integrator_square DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    simpson_integrator_square_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (req_ch),
        .i_out         (res_ch),
        .o_pending     (pending),
        .o_error_count (error_count)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Stall the result side at the same rate the request side idles.
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Present one request and hold it until the block takes it. Random idle cycles
    // go in front, so gaps land at any point of the block's sweep.
    task automatic send_request(
        input logic signed [IN_W-1:0] lo,
        input logic signed [IN_W-1:0] hi,
        input logic [COUNT_W-1:0]     cnt
    );
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.lower_bound    <= lo;
        req_ch.upper_bound    <= hi;
        req_ch.interval_count <= cnt;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
    endtask

    // Drop valid and hold off until every predicted result has come back. The
    // checker's count is registered, so wait for a clock edge before looking at it.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Bounds: full range, small values near zero, the extremes, and mid-range values.
    function automatic logic signed [IN_W-1:0] pick_bound();
        logic signed [IN_W-1:0] v;
        v = IN_W'($urandom);
        case ($urandom_range(3))
            0: ;
            1: v = {{(IN_W-18){v[17]}}, v[17:0]};
            2: begin
                case ($urandom_range(3))
                    0: v = 24'sh800000;
                    1: v = 24'sh7FFFFF;
                    2: v = 24'sh000000;
                    default: v = 24'shFFFFFF;
                endcase
            end
            default: v = {{(IN_W-20){v[19]}}, v[19:0]};
        endcase
        return v;
    endfunction

    // Counts: mostly short sweeps to keep the run short, a few zero counts and a
    // few longer sweeps.
    function automatic logic [COUNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        else if (roll < 65)
            return COUNT_W'($urandom_range(1, 32));
        else if (roll < 95)
            return COUNT_W'($urandom_range(33, 512));
        else
            return COUNT_W'($urandom_range(513, 4095));
    endfunction

    initial begin
        req_ch.valid          <= 1'b0;
        req_ch.lower_bound    <= '0;
        req_ch.upper_bound    <= '0;
        req_ch.interval_count <= '0;
        i_rst_n               <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: unit interval, odd counts raised by one, equal bounds,
        // reversed bounds (negative step), extremes of both bounds, zero counts.
        send_request(24'sh000000, 24'sh010000, 21'd2);
        send_request(24'sh010000, 24'sh030000, 21'd1);
        send_request(24'shFE0000, 24'sh050000, 21'd7);
        send_request(24'sh123456, 24'sh123456, 21'd10);
        send_request(24'sh400000, 24'shC00000, 21'd16);
        send_request(24'sh800000, 24'sh7FFFFF, 21'd2);
        send_request(24'sh7FFFFF, 24'sh800000, 21'd4);
        send_request(24'sh7FFFFF, 24'sh7FFFFF, 21'd3);
        send_request(24'sh800000, 24'sh800000, 21'd1);
        send_request(24'shFFFFFF, 24'sh000001, 21'd2);
        send_request(24'sh555555, 24'shAAAAAA, 21'd0);
        send_request(24'sh800000, 24'sh7FFFFF, 21'd0);
        send_request(24'sh000000, 24'sh000000, 21'd0);
        send_request(24'shFF0000, 24'sh010000, 21'd6);
        send_request(24'sh000010, 24'sh7FFFF0, 21'd4095);
        // all count bits set: clamped to the largest even count, the longest sweep
        send_request(24'sh800000, 24'sh7FFFFF, 21'h1FFFFF);

        // Hold the next request until the directed results are all back.
        wait_for_results();

        // Random: independent requests; a long stretch in the middle runs with
        // no idling on either side, and one more full drain sits inside it.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            idle_pct = (k >= 30 && k < 70) ? 0 : 8;
            if (k == 50)
                wait_for_results();
            send_request(pick_bound(), pick_bound(), pick_count());
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hard stop in case the block hangs or drops a result.
    initial begin
        #(LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/sis_pkg.sv
rtl/sis_if.sv
rtl/sis_div.sv
rtl/sis_dp.sv
rtl/sis_ctrl.sv
rtl/simpson_integrator_square.sv
sim/simpson_integrator_square_checker.sv
sim/simpson_integrator_square_tb.sv
